// File: hw/rtl/fpba_pkg.sv
// fpba_pkg: shared types and constants of the fit-policy block allocator.
// Field widths, command and register codes, fit modes, controller states.
// No dependencies.
`default_nettype none

package fpba_pkg;

	// fixed field widths of the ports
	localparam int CMD_W      = 1;
	localparam int BIDX_W     = 4;
	localparam int AMT_W      = 16;
	localparam int CAP_OUT_W  = 16;
	localparam int FIT_W      = 2;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// commands
	localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
	localparam logic [CMD_W-1:0] CMD_REQUEST = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

	// fit modes; the unused code behaves as first fit
	localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	// decoded policy broadcast to every cell
	typedef struct packed {
		logic best;
		logic worst;
	} srch_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/fpba_cell.sv
// fpba_cell: one capacity entry plus one stage of the search chain.
// Depends on fpba_pkg (srch_ctl_t).
`default_nettype none

module fpba_cell import fpba_pkg::*; #(
	parameter int IDX_W    = 4,
	parameter int SIZE_W   = 16,
	parameter int CELL_IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// shared write port (load or write-back)
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_idx,
	input  wire logic [SIZE_W-1:0] wr_data,
	// request context
	input  wire srch_ctl_t         ctl,
	input  wire logic [SIZE_W-1:0] amt,
	input  wire logic              in_use,
	// search word from the left neighbor
	input  wire logic              act_in,
	input  wire logic              found_in,
	input  wire logic [IDX_W-1:0]  pick_in,
	input  wire logic [SIZE_W-1:0] cap_in,
	// search word to the right neighbor
	output logic                   act_out,
	output logic                   found_out,
	output logic [IDX_W-1:0]       pick_out,
	output logic [SIZE_W-1:0]      cap_out
);

	logic [SIZE_W-1:0] cap_q;
	logic              act_q;
	logic              found_q;
	logic [IDX_W-1:0]  pick_q;
	logic [SIZE_W-1:0] pcap_q;
	logic              fits;
	logic              take;

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
			cap_q <= wr_data;
		end
	end

	// first fit keeps the earliest hit; best/worst replace on strict improvement
	always_comb begin
		fits = in_use && (cap_q >= amt);
		take = fits && (!found_in
			|| (ctl.best && (cap_q < cap_in))
			|| (ctl.worst && (cap_q > cap_in)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= act_in;
		end
	end

	always_ff @(posedge clk) begin
		found_q <= found_in || fits;
		pick_q  <= take ? IDX_W'(CELL_IDX) : pick_in;
		pcap_q  <= take ? cap_q : cap_in;
	end

	assign act_out   = act_q;
	assign found_out = found_q;
	assign pick_out  = pick_q;
	assign cap_out   = pcap_q;

endmodule

`default_nettype wire

// File: hw/rtl/fit_policy_block_allocator.sv
// fit_policy_block_allocator: top level, controller and chain of capacity cells.
// Depends on fpba_pkg and fpba_cell.
//
// Usage:
//  Input channel (in_valid/in_stall) carries one word: cmd, block_index, amount.
//  A load word (cmd 0) writes the capacity of block block_index and
//  gives no result; an index at or above NUM_BLOCKS is dropped. A request word
//  (cmd 1) gives exactly one result word on the output channel
//  (out_valid/out_stall): granted, chosen_block, capacity_left.
//  A request walks a search word through the row of NUM_BLOCKS cells, one cell
//  per cycle, then writes the chosen capacity back and fills the output
//  register. A request holds off the next word until its result has left the
//  controller; a load does not stall the input.
//  in_stall is high while a request is in flight.
//  Results wait in the output register while out_stall is high; a finished
//  search waits in the controller until that register frees up, and the input
//  stays stalled meanwhile.
//  Reset clears control state and sets fit_mode to first fit and block_count to
//  16. Capacities are undefined until loaded.
//  Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle; the block does not enforce this.
`default_nettype none

module fit_policy_block_allocator import fpba_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [CMD_W-1:0]      cmd,
	input  wire logic [BIDX_W-1:0]     block_index,
	input  wire logic [AMT_W-1:0]      amount,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       granted,
	output logic [BIDX_W-1:0]          chosen_block,
	output logic [CAP_OUT_W-1:0]       capacity_left
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	// configuration registers
	logic [FIT_W-1:0]   fit_mode_q;
	logic [COUNT_W-1:0] block_count_q;

	// controller
	state_t            state_q, state_d;
	logic              start_q;
	logic [SIZE_WIDTH-1:0] amt_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_pick_q;
	logic [SIZE_WIDTH-1:0] res_cap_q;

	// output register
	logic                 out_valid_q;
	logic                 granted_q;
	logic [BIDX_W-1:0]    chosen_q;
	logic [CAP_OUT_W-1:0] cap_left_q;

	// chain of search words, element 0 feeds cell 0
	logic                  act_c   [NUM_BLOCKS+1];
	logic                  found_c [NUM_BLOCKS+1];
	logic [IDX_W-1:0]      pick_c  [NUM_BLOCKS+1];
	logic [SIZE_WIDTH-1:0] cap_c   [NUM_BLOCKS+1];
	logic [NUM_BLOCKS-1:0] in_use;

	logic                  accept;
	logic                  load_wr;
	logic                  wb_wr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic [SIZE_WIDTH-1:0] wr_data;
	logic [SIZE_WIDTH-1:0] amt_in;
	logic [SIZE_WIDTH-1:0] cap_after;
	logic                  chain_done;
	logic                  out_free;
	logic                  emit;
	srch_ctl_t             ctl;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= FIT_FIRST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIT_MODE:    fit_mode_q    <= cfg_data[FIT_W-1:0];
				CFG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign ctl.best  = (fit_mode_q == FIT_BEST);
	assign ctl.worst = (fit_mode_q == FIT_WORST);

	// ---------------- input side ----------------
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign amt_in   = SIZE_WIDTH'(amount);

	// search word reaching the end of the row
	assign chain_done = act_c[NUM_BLOCKS];
	assign cap_after  = cap_c[NUM_BLOCKS] - amt_q;

	// one shared write port: loads when idle, write-back at end of search
	assign load_wr = accept && (cmd == CMD_LOAD) && (32'(block_index) < 32'(NUM_BLOCKS));
	assign wb_wr   = (state_q == ST_SEARCH) && chain_done && found_c[NUM_BLOCKS];
	assign wr_en   = load_wr || wb_wr;
	assign wr_idx  = wb_wr ? pick_c[NUM_BLOCKS] : IDX_W'(block_index);
	assign wr_data = wb_wr ? cap_after : amt_in;

	// ---------------- controller ----------------
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == CMD_REQUEST)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (chain_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && (cmd == CMD_REQUEST);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == CMD_REQUEST)) begin
			amt_q <= amt_in;
		end
		// capture the outcome; not granted reports zeros
		if ((state_q == ST_SEARCH) && chain_done) begin
			res_found_q <= found_c[NUM_BLOCKS];
			res_pick_q  <= found_c[NUM_BLOCKS] ? pick_c[NUM_BLOCKS] : '0;
			res_cap_q   <= found_c[NUM_BLOCKS] ? cap_after : '0;
		end
	end

	// ---------------- cell row ----------------
	assign act_c[0]   = start_q;
	assign found_c[0] = 1'b0;
	assign pick_c[0]  = '0;
	assign cap_c[0]   = '0;

	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		// cells past block_count are skipped; counts above the row length cap out
		assign in_use[i] = (32'(block_count_q) > 32'(i));

		fpba_cell #(
			.IDX_W    (IDX_W),
			.SIZE_W   (SIZE_WIDTH),
			.CELL_IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_en),
			.wr_idx    (wr_idx),
			.wr_data   (wr_data),
			.ctl       (ctl),
			.amt       (amt_q),
			.in_use    (in_use[i]),
			.act_in    (act_c[i]),
			.found_in  (found_c[i]),
			.pick_in   (pick_c[i]),
			.cap_in    (cap_c[i]),
			.act_out   (act_c[i+1]),
			.found_out (found_c[i+1]),
			.pick_out  (pick_c[i+1]),
			.cap_out   (cap_c[i+1])
		);
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			granted_q  <= res_found_q;
			chosen_q   <= BIDX_W'(res_pick_q);
			cap_left_q <= CAP_OUT_W'(res_cap_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign granted       = granted_q;
	assign chosen_block  = chosen_q;
	assign capacity_left = cap_left_q;

endmodule

`default_nettype wire

// File: hw/rtl/fpba_checker.sv
// fpba_checker: port-level assertions for fit_policy_block_allocator, and its bind.
// Depends on fpba_pkg.
`default_nettype none

module fpba_checker import fpba_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [CMD_W-1:0]     cmd,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 granted,
	input wire logic [BIDX_W-1:0]    chosen_block,
	input wire logic [CAP_OUT_W-1:0] capacity_left
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted)
			&& $stable(chosen_block) && $stable(capacity_left))
		else $error("stalled result word changed");

	// refused requests report zeros
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> (chosen_block == '0) && (capacity_left == '0))
		else $error("refused request with nonzero fields");

	// a request blocks the input while it searches
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_REQUEST) |=> in_stall)
		else $error("input taken during a search");

	// no result word right after a reset edge
	a_rst_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result word during reset");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.cmd           (cmd),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.granted       (granted),
	.chosen_block  (chosen_block),
	.capacity_left (capacity_left)
);

`default_nettype wire
